>>> src/pbs_pkg.sv
`timescale 1ns / 1ps

package pbs_pkg;

  localparam int unsigned JobIdW    = 7;
  localparam int unsigned BurstW    = 16;
  localparam int unsigned PrioW     = 8;
  localparam int unsigned TimeW     = 22;
  localparam int unsigned ElapsedW  = 23;
  localparam int unsigned TotalW    = 29;
  localparam int unsigned AvgW      = 30;
  localparam int unsigned FracW     = 8;
  localparam int unsigned DividendW = TotalW + FracW;
  localparam int unsigned StepW     = $clog2(DividendW + 1);

  typedef struct packed {
    logic [PrioW-1:0]  prio;
    logic [BurstW-1:0] burst;
    logic [JobIdW-1:0] id;
  } job_entry_t;

endpackage

>>> src/pbs_div.sv
`timescale 1ns / 1ps

module pbs_div
  import pbs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [JobIdW-1:0]    divisor_i,
  input  logic [DividendW-1:0] dvd_a_i,
  input  logic [DividendW-1:0] dvd_b_i,
  output logic                 done_o,
  output logic [AvgW-1:0]      quo_a_o,
  output logic [AvgW-1:0]      quo_b_o
);

  // Two restoring dividers share one divisor and one step counter.
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [StepW-1:0]     cnt_q, cnt_d;
  logic [JobIdW-1:0]    div_q, div_d;
  logic [DividendW-1:0] acc_q [2];
  logic [DividendW-1:0] acc_d [2];
  logic [JobIdW:0]      rem_q [2];
  logic [JobIdW:0]      rem_d [2];
  logic [DividendW-1:0] dvd_in [2];
  logic [JobIdW:0]      rem_sh [2];
  logic                 ge [2];

  assign dvd_in[0] = dvd_a_i;
  assign dvd_in[1] = dvd_b_i;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    done_d = 1'b0;
    for (int l = 0; l < 2; l++) begin
      rem_sh[l] = {rem_q[l][JobIdW-1:0], acc_q[l][DividendW-1]};
      ge[l]     = rem_sh[l] >= {1'b0, div_q};
      acc_d[l]  = acc_q[l];
      rem_d[l]  = rem_q[l];
    end
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      for (int l = 0; l < 2; l++) begin
        acc_d[l] = dvd_in[l];
        rem_d[l] = '0;
      end
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        acc_d[l] = {acc_q[l][DividendW-2:0], ge[l]};
        rem_d[l] = ge[l] ? (rem_sh[l] - {1'b0, div_q}) : rem_sh[l];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepW'(DividendW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    for (int l = 0; l < 2; l++) begin
      acc_q[l] <= acc_d[l];
      rem_q[l] <= rem_d[l];
    end
  end

  assign done_o  = done_q;
  assign quo_a_o = acc_q[0][AvgW-1:0];
  assign quo_b_o = acc_q[1][AvgW-1:0];

endmodule

>>> src/priority_batch_scheduler_top.sv
`timescale 1ns / 1ps

// Jobs are loaded one per cycle while busy is low; the job marked last closes the batch
// and raises busy. The stored jobs, held in one job RAM, are then ordered by a selection
// sort that scans the RAM one entry per cycle; each pass i ends with two swap writes, and
// passes run for i = 0 to n - 2 for n jobs. Results follow at one per cycle through the
// RAM read port, except the final result, which waits for the bit-serial averaging
// divider. Each result is shown for one cycle with valid_o high and cannot be held off;
// busy falls in the cycle that shows the final result.

module priority_batch_scheduler_top
  import pbs_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [BurstW-1:0] burst_time_i,
  input  logic [PrioW-1:0]  priority_req_i,
  input  logic              is_last_i,
  output logic              valid_o,
  output logic [JobIdW-1:0] job_id_o,
  output logic [BurstW-1:0] job_burst_o,
  output logic [TimeW-1:0]  wait_time_o,
  output logic [TimeW-1:0]  turnaround_time_o,
  output logic [TimeW-1:0]  completion_time_o,
  output logic [AvgW-1:0]   avg_wait_o,
  output logic [AvgW-1:0]   avg_turnaround_o,
  output logic              overflow_o,
  output logic              last_of_run_o
);

  localparam int unsigned CntW = $clog2(MAX_JOBS + 1);
  localparam int unsigned IdxW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  typedef enum logic [6:0] {
    S_LOAD   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_SWAP_P = 7'b0000100,
    S_SWAP_I = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_DSTART = 7'b0100000,
    S_DWAIT  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              dropped_q, dropped_d;
  logic [CntW-1:0]   i_q, i_d;
  logic [CntW-1:0]   k_q, k_d;
  logic              rd_vld_q, rd_vld_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic [CntW-1:0]   pos_q, pos_d;
  job_entry_t        best_q, best_d;
  job_entry_t        ent_i_q, ent_i_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [TotalW-1:0] wtot_q, wtot_d;
  logic [TotalW-1:0] ttot_q, ttot_d;
  logic              valid_q, valid_d;
  logic              last_q, last_d;
  logic [JobIdW-1:0] id_q, id_d;
  logic [BurstW-1:0] burst_q, burst_d;
  logic [TimeW-1:0]  wait_q, wait_d;
  logic [TimeW-1:0]  ta_q, ta_d;
  logic [AvgW-1:0]   avgw_q, avgw_d;
  logic [AvgW-1:0]   avgt_q, avgt_d;
  logic              ovf_q, ovf_d;

  job_entry_t        mem [MAX_JOBS];
  job_entry_t        rdata_q;
  logic              we;
  logic [IdxW-1:0]   waddr;
  job_entry_t        wdata;
  logic              re;

  logic              accept;
  logic              has_room;
  logic [CntW-1:0]   n_new;
  logic [CntW-1:0]   n_last;
  logic [CntW-1:0]   i_next;
  logic [ElapsedW-1:0] ta_sum;

  logic              div_start;
  logic              div_done;
  logic [AvgW-1:0]   quo_w;
  logic [AvgW-1:0]   quo_t;

  assign busy     = (state_q != S_LOAD);
  assign accept   = start && !busy;
  assign has_room = (count_q < CntW'(MAX_JOBS));
  assign n_new    = has_room ? (count_q + 1'b1) : count_q;
  assign n_last   = count_q - 1'b1;
  assign i_next   = i_q + 1'b1;
  assign re       = ((state_q == S_SCAN) || (state_q == S_EMIT)) && (k_q < count_q);
  assign ta_sum   = elapsed_q + ElapsedW'(rdata_q.burst);

  always_comb begin
    we    = 1'b0;
    waddr = count_q[IdxW-1:0];
    wdata = '{prio: priority_req_i, burst: burst_time_i, id: JobIdW'(count_q) + 1'b1};
    unique case (state_q)
      S_LOAD: begin
        we = accept && has_room;
      end
      S_SWAP_P: begin
        we    = 1'b1;
        waddr = pos_q[IdxW-1:0];
        wdata = ent_i_q;
      end
      S_SWAP_I: begin
        we    = 1'b1;
        waddr = i_q[IdxW-1:0];
        wdata = best_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[k_q[IdxW-1:0]];
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    i_d       = i_q;
    k_d       = re ? (k_q + 1'b1) : k_q;
    rd_vld_d  = re;
    rd_idx_d  = k_q;
    pos_d     = pos_q;
    best_d    = best_q;
    ent_i_d   = ent_i_q;
    elapsed_d = elapsed_q;
    wtot_d    = wtot_q;
    ttot_d    = ttot_q;
    valid_d   = 1'b0;
    last_d    = 1'b0;
    id_d      = id_q;
    burst_d   = burst_q;
    wait_d    = wait_q;
    ta_d      = ta_q;
    avgw_d    = avgw_q;
    avgt_d    = avgt_q;
    ovf_d     = ovf_q;
    div_start = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (has_room) begin
            count_d = count_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (is_last_i) begin
            i_d       = '0;
            k_d       = '0;
            elapsed_d = '0;
            wtot_d    = '0;
            ttot_d    = '0;
            state_d   = (n_new == CntW'(1)) ? S_EMIT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_q) begin
          if (rd_idx_q == i_q) begin
            best_d  = rdata_q;
            ent_i_d = rdata_q;
            pos_d   = i_q;
          end else if (rdata_q.prio > best_q.prio) begin
            best_d = rdata_q;
            pos_d  = rd_idx_q;
          end
          if (rd_idx_q == n_last) begin
            state_d = S_SWAP_P;
          end
        end
      end
      S_SWAP_P: begin
        state_d = S_SWAP_I;
      end
      S_SWAP_I: begin
        i_d = i_next;
        if (i_next == n_last) begin
          k_d     = '0;
          state_d = S_EMIT;
        end else begin
          k_d     = i_next;
          state_d = S_SCAN;
        end
      end
      S_EMIT: begin
        if (rd_vld_q) begin
          elapsed_d = ta_sum;
          wtot_d    = wtot_q + TotalW'(elapsed_q);
          ttot_d    = ttot_q + TotalW'(ta_sum);
          id_d      = rdata_q.id;
          burst_d   = rdata_q.burst;
          wait_d    = elapsed_q[TimeW-1:0];
          ta_d      = ta_sum[TimeW-1:0];
          avgw_d    = '0;
          avgt_d    = '0;
          ovf_d     = dropped_q;
          if (rd_idx_q == n_last) begin
            state_d = S_DSTART;
          end else begin
            valid_d = 1'b1;
          end
        end
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          avgw_d    = quo_w;
          avgt_d    = quo_t;
          valid_d   = 1'b1;
          last_d    = 1'b1;
          count_d   = '0;
          dropped_d = 1'b0;
          elapsed_d = '0;
          wtot_d    = '0;
          ttot_d    = '0;
          state_d   = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
      i_q       <= '0;
      k_q       <= '0;
      rd_vld_q  <= 1'b0;
      elapsed_q <= '0;
      wtot_q    <= '0;
      ttot_q    <= '0;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      i_q       <= i_d;
      k_q       <= k_d;
      rd_vld_q  <= rd_vld_d;
      elapsed_q <= elapsed_d;
      wtot_q    <= wtot_d;
      ttot_q    <= ttot_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    pos_q    <= pos_d;
    best_q   <= best_d;
    ent_i_q  <= ent_i_d;
    id_q     <= id_d;
    burst_q  <= burst_d;
    wait_q   <= wait_d;
    ta_q     <= ta_d;
    avgw_q   <= avgw_d;
    avgt_q   <= avgt_d;
    ovf_q    <= ovf_d;
  end

  pbs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (JobIdW'(count_q)),
    .dvd_a_i   ({wtot_q, FracW'(0)}),
    .dvd_b_i   ({ttot_q, FracW'(0)}),
    .done_o    (div_done),
    .quo_a_o   (quo_w),
    .quo_b_o   (quo_t)
  );

  assign valid_o           = valid_q;
  assign last_of_run_o     = last_q;
  assign job_id_o          = id_q;
  assign job_burst_o       = burst_q;
  assign wait_time_o       = wait_q;
  assign turnaround_time_o = ta_q;
  assign completion_time_o = ta_q;
  assign avg_wait_o        = avgw_q;
  assign avg_turnaround_o  = avgt_q;
  assign overflow_o        = ovf_q;

`ifndef ASSERT_OFF
  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_of_run_o |-> valid_o)
    else $error("last_of_run_o without a result transfer");

  a_avg_zero_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_of_run_o) |-> (avg_wait_o == '0 && avg_turnaround_o == '0))
    else $error("averages nonzero on a result that is not the last");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_of_run_o) |-> !busy)
    else $error("block still busy on the final result");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !is_last_i) |=> !valid_o)
    else $error("result produced by a job that does not close the batch");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pbs_pkg::*;

  localparam int unsigned MaxJobs    = 32;
  localparam int unsigned RandJobs   = 241;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [JobIdW-1:0] id;
    logic [BurstW-1:0] burst;
    logic [TimeW-1:0]  wait_t;
    logic [TimeW-1:0]  turnaround;
    logic [TimeW-1:0]  completion;
    logic [AvgW-1:0]   avg_wait;
    logic [AvgW-1:0]   avg_turnaround;
    logic              overflow;
    logic              last;
  } sched_rec_t;

  typedef struct packed {
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
    logic              last;
    logic              typed;
    sched_rec_t        want;
  } job_row_t;

  localparam int unsigned DirRows = 19;

  // Rows with typed results are single-job batches whose schedule is obvious.
  job_row_t job_table [DirRows] = '{
    '{16'hFFFF, 8'hFF, 1'b1, 1'b1,
      '{7'd1, 16'hFFFF, 22'd0, 22'd65535, 22'd65535, 30'd0, 30'd16776960, 1'b0, 1'b1}},
    '{16'h0000, 8'h00, 1'b1, 1'b1,
      '{7'd1, 16'h0000, 22'd0, 22'd0, 22'd0, 30'd0, 30'd0, 1'b0, 1'b1}},
    '{16'd10, 8'd1, 1'b0, 1'b0, '0},
    '{16'd20, 8'd5, 1'b0, 1'b0, '0},
    '{16'd30, 8'd1, 1'b0, 1'b0, '0},
    '{16'd40, 8'd5, 1'b1, 1'b0, '0},
    '{16'd100, 8'd0, 1'b0, 1'b0, '0},
    '{16'd200, 8'd1, 1'b0, 1'b0, '0},
    '{16'd300, 8'd2, 1'b0, 1'b0, '0},
    '{16'd400, 8'd3, 1'b1, 1'b0, '0},
    '{16'hFFFF, 8'd255, 1'b0, 1'b0, '0},
    '{16'd1, 8'd128, 1'b0, 1'b0, '0},
    '{16'h8000, 8'd127, 1'b0, 1'b0, '0},
    '{16'hFFFF, 8'd0, 1'b1, 1'b0, '0},
    '{16'd5, 8'd9, 1'b0, 1'b0, '0},
    '{16'd6, 8'd9, 1'b0, 1'b0, '0},
    '{16'd7, 8'd9, 1'b1, 1'b0, '0},
    '{16'd1, 8'd128, 1'b0, 1'b0, '0},
    '{16'hFFFF, 8'd127, 1'b1, 1'b0, '0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [BurstW-1:0] burst_time_i;
  logic [PrioW-1:0]  priority_req_i;
  logic              is_last_i;
  logic              valid_o;
  logic [JobIdW-1:0] job_id_o;
  logic [BurstW-1:0] job_burst_o;
  logic [TimeW-1:0]  wait_time_o;
  logic [TimeW-1:0]  turnaround_time_o;
  logic [TimeW-1:0]  completion_time_o;
  logic [AvgW-1:0]   avg_wait_o;
  logic [AvgW-1:0]   avg_turnaround_o;
  logic              overflow_o;
  logic              last_of_run_o;

  priority_batch_scheduler_top #(
    .MAX_JOBS(MaxJobs)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .burst_time_i(burst_time_i),
    .priority_req_i(priority_req_i),
    .is_last_i(is_last_i),
    .valid_o(valid_o),
    .job_id_o(job_id_o),
    .job_burst_o(job_burst_o),
    .wait_time_o(wait_time_o),
    .turnaround_time_o(turnaround_time_o),
    .completion_time_o(completion_time_o),
    .avg_wait_o(avg_wait_o),
    .avg_turnaround_o(avg_turnaround_o),
    .overflow_o(overflow_o),
    .last_of_run_o(last_of_run_o)
  );

  sched_rec_t        schedule_q [$];
  sched_rec_t        batch_sched [$];
  logic [BurstW-1:0] held_burst [MaxJobs];
  logic [PrioW-1:0]  held_prio [MaxJobs];
  int unsigned       held_count;
  logic              held_dropped;
  int unsigned       burst_left;
  int unsigned       jobs_sent;
  int unsigned       batches_closed;
  int unsigned       drop_batches;
  int unsigned       results_seen;
  int unsigned       mismatches;
  int unsigned       failures;
  int unsigned       cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic schedule_job(input logic [BurstW-1:0] burst, input logic [PrioW-1:0] prio,
                              input logic last);
    logic [JobIdW-1:0] ids [MaxJobs];
    logic [BurstW-1:0] tb;
    logic [PrioW-1:0]  tp;
    logic [JobIdW-1:0] tid;
    logic [PrioW-1:0]  best;
    int unsigned       pos;
    longint unsigned   elapsed;
    longint unsigned   wait_sum;
    longint unsigned   turn_sum;
    sched_rec_t        rec;
    batch_sched.delete();
    if (held_count < MaxJobs) begin
      held_burst[held_count] = burst;
      held_prio[held_count] = prio;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!last) return;
    for (int unsigned i = 0; i < held_count; i++) ids[i] = JobIdW'(i + 1);
    for (int unsigned i = 0; i < held_count; i++) begin
      best = held_prio[i];
      pos = i;
      for (int unsigned k = i; k < held_count; k++) begin
        if (held_prio[k] > best) begin
          best = held_prio[k];
          pos = k;
        end
      end
      tp = held_prio[i];  held_prio[i] = held_prio[pos];  held_prio[pos] = tp;
      tb = held_burst[i]; held_burst[i] = held_burst[pos]; held_burst[pos] = tb;
      tid = ids[i];       ids[i] = ids[pos];               ids[pos] = tid;
    end
    elapsed = 0;
    wait_sum = 0;
    turn_sum = 0;
    for (int unsigned i = 0; i < held_count; i++) begin
      rec = '0;
      rec.id = ids[i];
      rec.burst = held_burst[i];
      rec.wait_t = TimeW'(elapsed);
      rec.turnaround = TimeW'(elapsed + held_burst[i]);
      rec.completion = TimeW'(elapsed + held_burst[i]);
      rec.overflow = held_dropped;
      wait_sum += elapsed;
      elapsed += held_burst[i];
      turn_sum += elapsed;
      if (i == held_count - 1) begin
        rec.avg_wait = AvgW'((wait_sum << FracW) / longint'(held_count));
        rec.avg_turnaround = AvgW'((turn_sum << FracW) / longint'(held_count));
        rec.last = 1'b1;
      end
      batch_sched.push_back(rec);
    end
    batches_closed++;
    if (held_dropped) drop_batches++;
    held_count = 0;
    held_dropped = 1'b0;
  endtask

  // The sender runs in bursts of transfers separated by random gaps; some bursts
  // follow the previous one without any gap.
  task automatic send_job(input logic [BurstW-1:0] burst, input logic [PrioW-1:0] prio,
                          input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    burst_time_i <= burst;
    priority_req_i <= prio;
    is_last_i <= last;
    do @(posedge clk_i); while (busy);
    jobs_sent++;
    schedule_job(burst, prio, last);
  endtask

  task automatic send_batch(input int unsigned size, input bit max_burst);
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
    bit                tie_prone;
    tie_prone = ($urandom_range(0, 2) == 0);
    for (int unsigned j = 0; j < size; j++) begin
      case ($urandom_range(0, 3))
        0: burst = BurstW'($urandom_range(0, 15));
        1: burst = $urandom_range(0, 1) ? '1 : '0;
        default: burst = BurstW'($urandom_range(0, 65535));
      endcase
      if (max_burst) burst = '1;
      prio = tie_prone ? PrioW'($urandom_range(0, 2)) : PrioW'($urandom_range(0, 255));
      send_job(burst, prio, j == size - 1);
      while (batch_sched.size() != 0) schedule_q.push_back(batch_sched.pop_front());
    end
  endtask

  always @(posedge clk_i) begin
    sched_rec_t got;
    sched_rec_t want;
    if (rst_ni && valid_o) begin
      got = {job_id_o, job_burst_o, wait_time_o, turnaround_time_o, completion_time_o,
             avg_wait_o, avg_turnaround_o, overflow_o, last_of_run_o};
      results_seen++;
      if (schedule_q.size() == 0) begin
        failures++;
        $display("Unexpected result transfer for job %0d at %0t.", got.id, $realtime);
      end else begin
        want = schedule_q.pop_front();
        if (got !== want) begin
          failures++;
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("Mismatch at %0t (id burst wait turnaround completion avgw avgt ovf last):",
                     $realtime);
            $display("  expected %0d %0d %0d %0d %0d %0d %0d %0b %0b", want.id, want.burst,
                     want.wait_t, want.turnaround, want.completion, want.avg_wait,
                     want.avg_turnaround, want.overflow, want.last);
            $display("  actual   %0d %0d %0d %0d %0d %0d %0d %0b %0b", got.id, got.burst,
                     got.wait_t, got.turnaround, got.completion, got.avg_wait,
                     got.avg_turnaround, got.overflow, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               schedule_q.size());
      $display("priority_batch_scheduler_top regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned size;
    int unsigned pick;
    held_count = 0;
    held_dropped = 1'b0;
    burst_left = 0;
    jobs_sent = 0;
    batches_closed = 0;
    drop_batches = 0;
    results_seen = 0;
    mismatches = 0;
    failures = 0;
    cycles = 0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    burst_time_i <= '0;
    priority_req_i <= '0;
    is_last_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < DirRows; r++) begin
      send_job(job_table[r].burst, job_table[r].prio, job_table[r].last);
      if (job_table[r].typed) begin
        schedule_q.push_back(job_table[r].want);
      end else begin
        while (batch_sched.size() != 0) schedule_q.push_back(batch_sched.pop_front());
      end
    end

    start <= 1'b0;
    while (schedule_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);

    // A full batch of the longest jobs, a batch whose closing job is dropped,
    // and a batch that drops several jobs before closing.
    send_batch(MaxJobs, 1'b1);
    send_batch(MaxJobs + 1, 1'b0);
    send_batch(MaxJobs + 6, 1'b0);
    while (jobs_sent < DirRows + RandJobs) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) size = $urandom_range(1, 8);
      else if (pick < 18) size = $urandom_range(9, MaxJobs - 1);
      else size = $urandom_range(MaxJobs, MaxJobs + 8);
      send_batch(size, 1'b0);
    end

    start <= 1'b0;
    while (schedule_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (schedule_q.size() != 0) failures++;
    $display("Sent %0d jobs in %0d batches, %0d of them with dropped jobs.", jobs_sent,
             batches_closed, drop_batches);
    $display("Checked %0d result transfers, %0d mismatches, %0d failures in total.",
             results_seen, mismatches, failures);
    if (failures == 0) begin
      $display("priority_batch_scheduler_top regression: pass");
    end else begin
      $display("priority_batch_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/pbs_pkg.sv
src/pbs_div.sv
src/priority_batch_scheduler_top.sv
tb/sv/testbench.sv
